FILE: hw/rtl/rtprs_pkg.sv
// shared constants, types and helpers for the rtp receiver statistics block
`timescale 1ns / 1ps

package rtprs_pkg;

  // parameter defaults
  localparam int COUNT_WIDTH_DEF   = 48;
  localparam int FRAC_BITS_DEF     = 16;
  localparam int ARRIVAL_WIDTH_DEF = 40;
  localparam int JITTER_SHIFT_DEF  = 4;

  // fixed field widths
  localparam int RATE_W = 18;
  localparam int SEQ_W  = 16;
  localparam int TS_W   = 32;
  localparam int DIFF_W = SEQ_W + 2;

  localparam logic [RATE_W-1:0] CLOCK_RATE_RESET = RATE_W'(8000);

  // sequence wrap window
  localparam logic signed [DIFF_W-1:0] SEQ_HALF = DIFF_W'(32768);
  localparam logic signed [DIFF_W-1:0] SEQ_SPAN = DIFF_W'(65536);

  typedef enum logic {
    MODE_UPDATE = 1'b0,
    MODE_CLEAR  = 1'b1
  } mode_t;

  // signed width that holds arrival * rate - (timestamp << frac) exactly
  function automatic int transit_width(input int arrival_w, input int frac_bits);
    int prod_w;
    int shl_w;
    prod_w = arrival_w + RATE_W;
    shl_w  = TS_W + frac_bits;
    return ((prod_w > shl_w) ? prod_w : shl_w) + 1;
  endfunction

endpackage

FILE: hw/rtl/rtprs_transit.sv
// transit time: arrival time scaled to media clock minus sender timestamp
`timescale 1ns / 1ps

module rtprs_transit #(
  parameter int ARRIVAL_WIDTH = rtprs_pkg::ARRIVAL_WIDTH_DEF,
  parameter int FRAC_BITS     = rtprs_pkg::FRAC_BITS_DEF
) (
  input  logic [ARRIVAL_WIDTH-1:0]    arrival_time,
  input  logic [rtprs_pkg::RATE_W-1:0] clock_rate,
  input  logic [rtprs_pkg::TS_W-1:0]   media_timestamp,
  output logic signed [rtprs_pkg::transit_width(ARRIVAL_WIDTH, FRAC_BITS)-1:0] transit
);

  localparam int TW     = rtprs_pkg::transit_width(ARRIVAL_WIDTH, FRAC_BITS);
  localparam int PROD_W = ARRIVAL_WIDTH + rtprs_pkg::RATE_W;
  localparam int SHL_W  = rtprs_pkg::TS_W + FRAC_BITS;

  logic [PROD_W-1:0] prod;
  logic [SHL_W-1:0]  ts_shl;

  assign prod   = PROD_W'(arrival_time) * PROD_W'(clock_rate);
  assign ts_shl = {media_timestamp, {FRAC_BITS{1'b0}}};
  assign transit = $signed(TW'(prod)) - $signed(TW'(ts_shl));

endmodule

FILE: hw/rtl/rtprs_jitter.sv
// interarrival jitter filter step: j += floor((|d| - j) / 2^shift)
`timescale 1ns / 1ps

module rtprs_jitter #(
  parameter int COUNT_WIDTH  = rtprs_pkg::COUNT_WIDTH_DEF,
  parameter int JITTER_SHIFT = rtprs_pkg::JITTER_SHIFT_DEF,
  parameter int TRANSIT_W    = rtprs_pkg::transit_width(rtprs_pkg::ARRIVAL_WIDTH_DEF,
                                                        rtprs_pkg::FRAC_BITS_DEF)
) (
  input  logic signed [TRANSIT_W-1:0] transit,
  input  logic signed [TRANSIT_W-1:0] prev_transit,
  input  logic [COUNT_WIDTH-1:0]      jitter_in,
  output logic [COUNT_WIDTH-1:0]      jitter_out
);

  localparam int MW = (TRANSIT_W > COUNT_WIDTH) ? TRANSIT_W : COUNT_WIDTH;

  logic signed [TRANSIT_W:0]   diff;
  logic [TRANSIT_W:0]          mag;
  logic [MW-1:0]               mag_ext;
  logic [COUNT_WIDTH-1:0]      d_sat;
  logic signed [COUNT_WIDTH:0] delta;
  logic signed [COUNT_WIDTH:0] step;

  always_comb begin
    diff    = $signed({transit[TRANSIT_W-1], transit})
            - $signed({prev_transit[TRANSIT_W-1], prev_transit});
    mag     = diff[TRANSIT_W] ? (TRANSIT_W + 1)'(-diff) : diff;
    // magnitude never exceeds 2^TRANSIT_W - 1
    mag_ext = MW'(mag[TRANSIT_W-1:0]);
    if (mag_ext > MW'({COUNT_WIDTH{1'b1}})) begin
      d_sat = {COUNT_WIDTH{1'b1}};
    end else begin
      d_sat = mag_ext[COUNT_WIDTH-1:0];
    end
    delta      = $signed({1'b0, d_sat}) - $signed({1'b0, jitter_in});
    step       = delta >>> JITTER_SHIFT;
    jitter_out = jitter_in + step[COUNT_WIDTH-1:0];
  end

endmodule

FILE: hw/rtl/rtp_receiver_statistics.sv
// rtp receiver statistics: sequence extension, loss counts and interarrival jitter
// pipeline: input register, then result register (two register stages); one request per
// cycle unless in_stall; the transit multiply sits before the input register
// and the statistics update sits between the input register and the result register
// reset (rst_n low, synchronous): statistics cleared, both stages empty, clock_rate = 8000
// in_stall rises only while the input stage is full and the result register is held
`timescale 1ns / 1ps

module rtp_receiver_statistics #(
  parameter int COUNT_WIDTH   = rtprs_pkg::COUNT_WIDTH_DEF,
  parameter int FRAC_BITS     = rtprs_pkg::FRAC_BITS_DEF,
  parameter int ARRIVAL_WIDTH = rtprs_pkg::ARRIVAL_WIDTH_DEF,
  parameter int JITTER_SHIFT  = rtprs_pkg::JITTER_SHIFT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_wr_en,
  input  logic [rtprs_pkg::RATE_W-1:0]  cfg_wr_data,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_mode,
  input  logic [rtprs_pkg::SEQ_W-1:0]   in_seq_number,
  input  logic [rtprs_pkg::TS_W-1:0]    in_media_timestamp,
  input  logic [ARRIVAL_WIDTH-1:0]      in_arrival_time,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COUNT_WIDTH-1:0] out_extended_seq,
  output logic [COUNT_WIDTH-1:0]        out_packets_received,
  output logic [COUNT_WIDTH-1:0]        out_packets_reordered,
  output logic [COUNT_WIDTH-1:0]        out_packets_expected,
  output logic [COUNT_WIDTH-1:0]        out_packets_lost,
  output logic [COUNT_WIDTH-1:0]        out_jitter_estimate
);

  localparam int TW     = rtprs_pkg::transit_width(ARRIVAL_WIDTH, FRAC_BITS);
  localparam int DIFF_W = rtprs_pkg::DIFF_W;
  localparam int SEQ_W  = rtprs_pkg::SEQ_W;

  // largest positive extended sequence number
  localparam logic [COUNT_WIDTH-1:0] EXT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};

  // ---------------------------------------------------------------------------
  // configuration register
  // ---------------------------------------------------------------------------
  logic [rtprs_pkg::RATE_W-1:0] clock_rate_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_rate_r <= rtprs_pkg::CLOCK_RATE_RESET;
    end else if (cfg_wr_en) begin
      clock_rate_r <= cfg_wr_data;
    end
  end

  // ---------------------------------------------------------------------------
  // handshake and stage control
  // ---------------------------------------------------------------------------
  logic s1_valid_r;
  logic out_valid_r;
  logic in_accept;
  logic out_load_ok;   // result register free or being emptied this cycle
  logic s1_advance;    // input stage moves into the result register

  assign out_load_ok = !out_valid_r || !out_stall;
  assign in_stall    = s1_valid_r && !out_load_ok;
  assign in_accept   = in_valid && !in_stall;
  assign s1_advance  = s1_valid_r && out_load_ok;
  assign out_valid   = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_advance) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_advance) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // input stage: transit is formed on the way in, so the multiply has its own register
  // ---------------------------------------------------------------------------
  logic signed [TW-1:0] in_transit;
  rtprs_pkg::mode_t     s1_mode_r;
  logic [SEQ_W-1:0]     s1_seq_r;
  logic signed [TW-1:0] s1_transit_r;

  rtprs_transit #(
    .ARRIVAL_WIDTH (ARRIVAL_WIDTH),
    .FRAC_BITS     (FRAC_BITS)
  ) u_transit (
    .arrival_time    (in_arrival_time),
    .clock_rate      (clock_rate_r),
    .media_timestamp (in_media_timestamp),
    .transit         (in_transit)
  );

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_mode_r    <= rtprs_pkg::mode_t'(in_mode);
      s1_seq_r     <= in_seq_number;
      s1_transit_r <= in_transit;
    end
  end

  // ---------------------------------------------------------------------------
  // statistics state
  // ---------------------------------------------------------------------------
  logic                   seen_first_r;
  logic [COUNT_WIDTH-1:0] first_ext_r;     // never negative
  logic [COUNT_WIDTH-1:0] highest_ext_r;   // never negative, only grows until a clear request
  logic [COUNT_WIDTH-1:0] received_r;
  logic [COUNT_WIDTH-1:0] reordered_r;
  logic signed [TW-1:0]   prev_transit_r;
  logic [COUNT_WIDTH-1:0] jitter_r;

  logic                   seen_first_nxt;
  logic [COUNT_WIDTH-1:0] first_ext_nxt;
  logic [COUNT_WIDTH-1:0] highest_ext_nxt;
  logic [COUNT_WIDTH-1:0] received_nxt;
  logic [COUNT_WIDTH-1:0] reordered_nxt;
  logic signed [TW-1:0]   prev_transit_nxt;
  logic [COUNT_WIDTH-1:0] jitter_nxt;

  logic [COUNT_WIDTH-1:0] ext_seq_nxt;
  logic [COUNT_WIDTH-1:0] expected_nxt;
  logic [COUNT_WIDTH-1:0] lost_nxt;

  // sequence extension against the highest number seen
  logic signed [DIFF_W-1:0] seq_diff;
  logic signed [DIFF_W-1:0] seq_diff_adj;
  logic [COUNT_WIDTH:0]     ext_wide;
  logic [COUNT_WIDTH-1:0]   ext_sat;
  logic [COUNT_WIDTH-1:0]   jitter_upd;

  always_comb begin
    // highest is never negative, so its remainder by 65536 is its low half
    seq_diff = $signed({2'b00, s1_seq_r}) - $signed({2'b00, highest_ext_r[SEQ_W-1:0]});
    if (seq_diff > rtprs_pkg::SEQ_HALF) begin
      seq_diff_adj = seq_diff - rtprs_pkg::SEQ_SPAN;
    end else if (seq_diff < -rtprs_pkg::SEQ_HALF) begin
      seq_diff_adj = seq_diff + rtprs_pkg::SEQ_SPAN;
    end else begin
      seq_diff_adj = seq_diff;
    end
    ext_wide = {1'b0, highest_ext_r}
             + {{(COUNT_WIDTH + 1 - DIFF_W){seq_diff_adj[DIFF_W-1]}}, seq_diff_adj};
    // only the positive end can overflow
    if (ext_wide[COUNT_WIDTH:COUNT_WIDTH-1] == 2'b01) begin
      ext_sat = EXT_MAX;
    end else begin
      ext_sat = ext_wide[COUNT_WIDTH-1:0];
    end
  end

  rtprs_jitter #(
    .COUNT_WIDTH  (COUNT_WIDTH),
    .JITTER_SHIFT (JITTER_SHIFT),
    .TRANSIT_W    (TW)
  ) u_jitter (
    .transit      (s1_transit_r),
    .prev_transit (prev_transit_r),
    .jitter_in    (jitter_r),
    .jitter_out   (jitter_upd)
  );

  always_comb begin
    seen_first_nxt   = seen_first_r;
    first_ext_nxt    = first_ext_r;
    highest_ext_nxt  = highest_ext_r;
    received_nxt     = received_r;
    reordered_nxt    = reordered_r;
    prev_transit_nxt = prev_transit_r;
    jitter_nxt       = jitter_r;
    ext_seq_nxt      = '0;
    expected_nxt     = '0;
    lost_nxt         = '0;

    if (s1_mode_r == rtprs_pkg::MODE_CLEAR) begin
      // clear request: everything back to reset, result all zeros
      seen_first_nxt   = 1'b0;
      first_ext_nxt    = '0;
      highest_ext_nxt  = '0;
      received_nxt     = '0;
      reordered_nxt    = '0;
      prev_transit_nxt = '0;
      jitter_nxt       = '0;
    end else begin
      if (!seen_first_r) begin
        // first packet since clear seeds the range, jitter untouched
        ext_seq_nxt     = COUNT_WIDTH'(s1_seq_r);
        first_ext_nxt   = COUNT_WIDTH'(s1_seq_r);
        highest_ext_nxt = COUNT_WIDTH'(s1_seq_r);
      end else begin
        ext_seq_nxt = ext_sat;
        if ($signed(ext_sat) < $signed(highest_ext_r)) begin
          reordered_nxt = (&reordered_r) ? reordered_r : reordered_r + 1'b1;
        end
        if ($signed(ext_sat) > $signed(highest_ext_r)) begin
          highest_ext_nxt = ext_sat;
        end
        jitter_nxt = jitter_upd;
      end
      seen_first_nxt   = 1'b1;
      prev_transit_nxt = s1_transit_r;
      received_nxt     = (&received_r) ? received_r : received_r + 1'b1;
      // highest stays at or below the signed maximum, so the +1 cannot wrap
      expected_nxt     = highest_ext_nxt - first_ext_nxt + 1'b1;
      lost_nxt         = (expected_nxt > received_nxt) ? expected_nxt - received_nxt : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_first_r   <= 1'b0;
      first_ext_r    <= '0;
      highest_ext_r  <= '0;
      received_r     <= '0;
      reordered_r    <= '0;
      prev_transit_r <= '0;
      jitter_r       <= '0;
    end else if (s1_advance) begin
      seen_first_r   <= seen_first_nxt;
      first_ext_r    <= first_ext_nxt;
      highest_ext_r  <= highest_ext_nxt;
      received_r     <= received_nxt;
      reordered_r    <= reordered_nxt;
      prev_transit_r <= prev_transit_nxt;
      jitter_r       <= jitter_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_extended_seq      <= $signed(ext_seq_nxt);
      out_packets_received  <= received_nxt;
      out_packets_reordered <= reordered_nxt;
      out_packets_expected  <= expected_nxt;
      out_packets_lost      <= lost_nxt;
      out_jitter_estimate   <= jitter_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // back-pressure only comes from a held result with a full input stage
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("in_stall without a held result");

  // a clear request leaves the statistics empty
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_advance && s1_mode_r == rtprs_pkg::MODE_CLEAR) |=>
      (!seen_first_r && received_r == '0 && reordered_r == '0 && jitter_r == '0))
    else $error("statistics not cleared");

  // lost never exceeds expected
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_packets_lost <= out_packets_expected))
    else $error("lost count above expected count");

  // reordered packets are a subset of received ones
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_packets_reordered <= out_packets_received))
    else $error("reordered count above received count");

endmodule

FILE: bench/rtp_stats_checker.sv
// result checker for the rtp receiver statistics block: tracks the statistics and compares
`timescale 1ns / 1ps

module rtp_stats_checker (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [rtprs_pkg::RATE_W-1:0]          cfg_wr_data,
  input  logic                                  in_valid,
  input  logic                                  in_stall,
  input  logic                                  in_mode,
  input  logic [rtprs_pkg::SEQ_W-1:0]           in_seq_number,
  input  logic [rtprs_pkg::TS_W-1:0]            in_media_timestamp,
  input  logic [rtprs_pkg::ARRIVAL_WIDTH_DEF-1:0] in_arrival_time,
  input  logic                                  out_valid,
  input  logic                                  out_stall,
  input  logic [rtprs_pkg::COUNT_WIDTH_DEF-1:0] out_extended_seq,
  input  logic [rtprs_pkg::COUNT_WIDTH_DEF-1:0] out_packets_received,
  input  logic [rtprs_pkg::COUNT_WIDTH_DEF-1:0] out_packets_reordered,
  input  logic [rtprs_pkg::COUNT_WIDTH_DEF-1:0] out_packets_expected,
  input  logic [rtprs_pkg::COUNT_WIDTH_DEF-1:0] out_packets_lost,
  input  logic [rtprs_pkg::COUNT_WIDTH_DEF-1:0] out_jitter_estimate,
  output int                                    fail_count,
  output int                                    pending
);

  localparam int CW = rtprs_pkg::COUNT_WIDTH_DEF;
  localparam int FB = rtprs_pkg::FRAC_BITS_DEF;
  localparam int JS = rtprs_pkg::JITTER_SHIFT_DEF;
  localparam longint unsigned COUNT_ALL = (64'd1 << CW) - 64'd1;
  localparam longint EXT_TOP = (64'sd1 <<< (CW - 1)) - 64'sd1;
  localparam longint EXT_BOT = -EXT_TOP - 64'sd1;

  typedef struct packed {
    logic [CW-1:0] extended_seq;
    logic [CW-1:0] packets_received;
    logic [CW-1:0] packets_reordered;
    logic [CW-1:0] packets_expected;
    logic [CW-1:0] packets_lost;
    logic [CW-1:0] jitter_estimate;
  } rx_stats_t;

  // running receiver state
  logic [rtprs_pkg::RATE_W-1:0] media_rate;
  bit                           have_first;
  longint                       base_ext;
  longint                       top_ext;
  longint unsigned              rx_count;
  longint unsigned              late_count;
  longint                       last_transit;
  longint unsigned              jitter_q;

  rx_stats_t stats_due[$];
  rx_stats_t want;
  int        bad_results = 0;

  function automatic longint unsigned sat_bump(input longint unsigned v);
    return (v >= COUNT_ALL) ? COUNT_ALL : v + 64'd1;
  endfunction

  // place seq within half a wrap of the highest extended number
  function automatic longint extend_seq_num(input logic [15:0] seq, input longint anchor);
    longint diff;
    longint ext;
    diff = longint'(seq) - (anchor % 64'sd65536);
    while (diff > 64'sd32768) diff -= 64'sd65536;
    while (diff < -64'sd32768) diff += 64'sd65536;
    ext = anchor + diff;
    if (ext > EXT_TOP) ext = EXT_TOP;
    if (ext < EXT_BOT) ext = EXT_BOT;
    return ext;
  endfunction

  function automatic void clear_stats();
    have_first   = 1'b0;
    base_ext     = 0;
    top_ext      = 0;
    rx_count     = 0;
    late_count   = 0;
    last_transit = 0;
    jitter_q     = 0;
  endfunction

  function automatic rx_stats_t account_packet(input logic [15:0] seq, input logic [31:0] ts,
                                               input logic [39:0] arr);
    rx_stats_t       res;
    longint          ext;
    longint          transit;
    longint          delta;
    longint unsigned arr_u;
    longint unsigned ts_u;
    longint unsigned spread;
    longint unsigned step_mag;
    longint unsigned span;
    longint unsigned lost;
    arr_u   = 64'(arr);
    ts_u    = 64'(ts);
    transit = signed'(arr_u * 64'(media_rate)) - signed'(ts_u << FB);
    if (!have_first) begin
      ext      = longint'(seq);
      base_ext = ext;
      top_ext  = ext;
    end else begin
      ext = extend_seq_num(seq, top_ext);
      if (ext < top_ext) late_count = sat_bump(late_count);
      if (ext > top_ext) top_ext = ext;
      spread = unsigned'(transit) - unsigned'(last_transit);
      if (transit < last_transit) spread = 64'd0 - spread;
      if (spread > COUNT_ALL) spread = COUNT_ALL;
      delta = signed'(spread) - signed'(jitter_q);
      if (delta >= 0) begin
        step_mag = unsigned'(delta);
        jitter_q = jitter_q + (step_mag >> JS);
      end else begin
        // negative steps round away from zero
        step_mag = unsigned'(-delta);
        jitter_q = jitter_q - ((step_mag + ((64'd1 << JS) - 64'd1)) >> JS);
      end
    end
    have_first   = 1'b1;
    last_transit = transit;
    rx_count     = sat_bump(rx_count);
    span = unsigned'(top_ext - base_ext);
    span = (span >= COUNT_ALL) ? COUNT_ALL : span + 64'd1;
    lost = (span > rx_count) ? span - rx_count : 64'd0;
    res.extended_seq      = ext[CW-1:0];
    res.packets_received  = rx_count[CW-1:0];
    res.packets_reordered = late_count[CW-1:0];
    res.packets_expected  = span[CW-1:0];
    res.packets_lost      = lost[CW-1:0];
    res.jitter_estimate   = jitter_q[CW-1:0];
    return res;
  endfunction

  task automatic check_field(input string name, input logic [CW-1:0] exp_v,
                             input logic [CW-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
      bad_results++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_stats();
      media_rate = rtprs_pkg::CLOCK_RATE_RESET;
      stats_due.delete();
    end else begin
      // results first: a result at this edge belongs to an older request
      if (out_valid && !out_stall) begin
        if (stats_due.size() == 0) begin
          $error("unexpected result: extended_seq %0h", out_extended_seq);
          bad_results++;
        end else begin
          want = stats_due.pop_front();
          check_field("extended_seq", want.extended_seq, out_extended_seq);
          check_field("packets_received", want.packets_received, out_packets_received);
          check_field("packets_reordered", want.packets_reordered, out_packets_reordered);
          check_field("packets_expected", want.packets_expected, out_packets_expected);
          check_field("packets_lost", want.packets_lost, out_packets_lost);
          check_field("jitter_estimate", want.jitter_estimate, out_jitter_estimate);
        end
      end
      if (in_valid && !in_stall) begin
        if (in_mode == rtprs_pkg::MODE_CLEAR) begin
          clear_stats();
          stats_due.push_back('0);
        end else begin
          stats_due.push_back(account_packet(in_seq_number, in_media_timestamp,
                                             in_arrival_time));
        end
      end
      // the rate register updates after the request at this edge has used the old one
      if (cfg_wr_en) media_rate = cfg_wr_data;
    end
    fail_count <= bad_results;
    pending    <= stats_due.size();
  end

endmodule

FILE: bench/rtp_receiver_statistics_tb.sv
// top of the rtp receiver statistics bench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module rtp_receiver_statistics_tb;

  localparam int CW = rtprs_pkg::COUNT_WIDTH_DEF;
  localparam int AW = rtprs_pkg::ARRIVAL_WIDTH_DEF;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 168;
  // far beyond the slowest legal run of all phases
  localparam int unsigned RUN_LIMIT_NS = 3_000_000;
  // nominal packet spacing of 20 ms in Q16 seconds
  localparam int unsigned ARR_STEP = 1311;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_wr_en = 1'b0;
  logic [rtprs_pkg::RATE_W-1:0] cfg_wr_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic                         in_mode = 1'b0;
  logic [rtprs_pkg::SEQ_W-1:0]  in_seq_number = '0;
  logic [rtprs_pkg::TS_W-1:0]   in_media_timestamp = '0;
  logic [AW-1:0]                in_arrival_time = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic signed [CW-1:0]         out_extended_seq;
  logic [CW-1:0]                out_packets_received;
  logic [CW-1:0]                out_packets_reordered;
  logic [CW-1:0]                out_packets_expected;
  logic [CW-1:0]                out_packets_lost;
  logic [CW-1:0]                out_jitter_estimate;

  int fail_count;
  int pending;

  // idle and stall odds, in percent per cycle
  int send_idle_pct = 0;
  int stall_pct = 0;

  rtp_receiver_statistics DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_wr_data           (cfg_wr_data),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_mode               (in_mode),
    .in_seq_number         (in_seq_number),
    .in_media_timestamp    (in_media_timestamp),
    .in_arrival_time       (in_arrival_time),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_extended_seq      (out_extended_seq),
    .out_packets_received  (out_packets_received),
    .out_packets_reordered (out_packets_reordered),
    .out_packets_expected  (out_packets_expected),
    .out_packets_lost      (out_packets_lost),
    .out_jitter_estimate   (out_jitter_estimate)
  );

  // the checker sees the same edges as the block and keeps its own statistics
  rtp_stats_checker stats_check (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_wr_data           (cfg_wr_data),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_mode               (in_mode),
    .in_seq_number         (in_seq_number),
    .in_media_timestamp    (in_media_timestamp),
    .in_arrival_time       (in_arrival_time),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_extended_seq      (out_extended_seq),
    .out_packets_received  (out_packets_received),
    .out_packets_reordered (out_packets_reordered),
    .out_packets_expected  (out_packets_expected),
    .out_packets_lost      (out_packets_lost),
    .out_jitter_estimate   (out_jitter_estimate),
    .fail_count            (fail_count),
    .pending               (pending)
  );

  // 12 ns clock
  initial begin
    forever #6 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #(RUN_LIMIT_NS);
    $display("TEST FAILED");
    $finish;
  end

  // result side back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  function automatic logic [AW-1:0] rand_arrival();
    return {8'($urandom), 32'($urandom)};
  endfunction

  // one request: random idle cycles first, then hold it until it is taken
  task automatic send_req(input rtprs_pkg::mode_t m, input logic [15:0] seq,
                          input logic [31:0] ts, input logic [AW-1:0] arr);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_mode            <= m;
    in_seq_number      <= seq;
    in_media_timestamp <= ts;
    in_arrival_time    <= arr;
    do @(posedge clk); while (in_stall);
  endtask

  // drop valid, wait until every request has its result, then let the pipe settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_clock_rate(input logic [rtprs_pkg::RATE_W-1:0] rate);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= rate;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    logic [15:0]                  cur_seq;
    logic [31:0]                  cur_ts;
    logic [31:0]                  ts_step;
    logic [AW-1:0]                cur_arr;
    logic [rtprs_pkg::RATE_W-1:0] rate;
    int                           kind;
    int                           hop;

    // synchronous reset held low first, then released
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at the reset clock rate
    // first packet, then a normal follower
    send_req(rtprs_pkg::MODE_UPDATE, 16'd0, 32'd0, 40'd0);
    send_req(rtprs_pkg::MODE_UPDATE, 16'd1, 32'd160, 40'd1311);
    // one step back across zero gives a negative extended number
    send_req(rtprs_pkg::MODE_UPDATE, 16'd65535, 32'd0, 40'd2600);
    // exactly half a wrap ahead keeps moving forward
    send_req(rtprs_pkg::MODE_UPDATE, 16'd32769, 32'd320, 40'd3900);
    // exactly half a wrap behind the new highest counts as late
    send_req(rtprs_pkg::MODE_UPDATE, 16'd1, 32'd480, 40'd5200);
    // duplicate
    send_req(rtprs_pkg::MODE_UPDATE, 16'd1, 32'd480, 40'd5200);
    // clear with every payload bit set
    send_req(rtprs_pkg::MODE_CLEAR, 16'hFFFF, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF);
    // extremes after clear: a huge transit swing saturates the jitter input
    send_req(rtprs_pkg::MODE_UPDATE, 16'hFFFF, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF);
    send_req(rtprs_pkg::MODE_UPDATE, 16'd0, 32'd0, 40'd0);
    send_req(rtprs_pkg::MODE_UPDATE, 16'd32767, 32'd100, 40'd1000);
    // steady packets let the jitter decay, with round-up on the way down
    for (int k = 1; k <= 6; k++) begin
      send_req(rtprs_pkg::MODE_UPDATE, 16'(32767 + k), 32'(100 + 160 * k),
               40'(1000 + 1311 * k + 37 * (k % 3)));
    end
    send_req(rtprs_pkg::MODE_CLEAR, 16'd0, 32'd0, 40'd0);
    // half a wrap behind right after the first packet
    send_req(rtprs_pkg::MODE_UPDATE, 16'd40000, 32'd1000, 40'd100000);
    send_req(rtprs_pkg::MODE_UPDATE, 16'd7232, 32'd1160, 40'd101311);
    // forward across the wrap from a high anchor
    send_req(rtprs_pkg::MODE_UPDATE, 16'd0, 32'd1320, 40'd102622);

    // random phases: each one a new clock rate and a new idling pattern
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      case (p)
        0:       rate = 18'd1;
        1:       rate = 18'd262143;
        2:       rate = 18'd0;
        3:       rate = 18'd8000;
        4:       rate = 18'd90000;
        5:       rate = 18'($urandom_range(1, 262143));
        6:       rate = 18'd48000;
        default: rate = 18'd262143;
      endcase
      set_clock_rate(rate);
      case (p % 4)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 76; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 76; end
        default: begin send_idle_pct = 30; stall_pct = 30; end
      endcase

      // fresh stream; odd phases start just below the wrap
      cur_seq = 16'($urandom);
      if (p % 2 == 1) cur_seq = 16'(65535 - $urandom_range(0, 60));
      cur_ts  = $urandom;
      cur_arr = rand_arrival();
      ts_step = 32'(rate / 50 + 1);

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        kind = $urandom_range(0, 99);
        if (kind < 3) begin
          // clear with random leftovers in the payload
          send_req(rtprs_pkg::MODE_CLEAR, 16'($urandom), $urandom, rand_arrival());
        end else if (kind < 10) begin
          // noise: every field random
          send_req(rtprs_pkg::MODE_UPDATE, 16'($urandom), $urandom, rand_arrival());
        end else if (kind < 15) begin
          // late packet from a little way back
          hop = $urandom_range(1, 64);
          send_req(rtprs_pkg::MODE_UPDATE, cur_seq - 16'(hop), cur_ts - ts_step * 32'(hop),
                   cur_arr + 40'($urandom_range(0, 900)));
        end else if (kind < 18) begin
          // burst loss, sometimes past half a wrap
          hop = $urandom_range(100, 40000);
          cur_seq = cur_seq + 16'(hop);
          cur_ts  = cur_ts + ts_step * 32'(hop);
          cur_arr = cur_arr + 40'(ARR_STEP * hop);
          send_req(rtprs_pkg::MODE_UPDATE, cur_seq, cur_ts, cur_arr);
        end else if (kind < 20) begin
          // duplicate of the newest packet
          send_req(rtprs_pkg::MODE_UPDATE, cur_seq, cur_ts,
                   cur_arr + 40'($urandom_range(0, 2000)));
        end else begin
          // in-order packet, small losses now and then, arrival jitter on top
          hop = (kind < 30) ? $urandom_range(2, 6) : 1;
          cur_seq = cur_seq + 16'(hop);
          cur_ts  = cur_ts + ts_step * 32'(hop);
          cur_arr = cur_arr + 40'(ARR_STEP * hop);
          send_req(rtprs_pkg::MODE_UPDATE, cur_seq, cur_ts,
                   cur_arr + 40'($urandom_range(0, 900)));
        end
      end
    end

    wait_drained();
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: rtp_receiver_statistics.f
hw/rtl/rtprs_pkg.sv
hw/rtl/rtprs_transit.sv
hw/rtl/rtprs_jitter.sv
hw/rtl/rtp_receiver_statistics.sv
bench/rtp_stats_checker.sv
bench/rtp_receiver_statistics_tb.sv
